// ===== hw/rtl/ecr_pkg.sv =====
package ecr_pkg;

  localparam int COLOR_W = 24;
  localparam int CHAN_W = 8;
  localparam int NUM_CHAN = 3;
  localparam int HEIGHT_WIDTH_DEF = 16;
  localparam int Q_W = 7;
  localparam int SUM_W = 15;
  localparam int PCT_FULL = 100;
  localparam int DIV100_MUL = 5243;
  localparam int DIV100_SHIFT = 19;
  localparam int PROD_W = 28;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_HEIGHT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_COLOR = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_COLOR = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MID_COLOR = 3'd4;

  localparam logic [COLOR_W-1:0] LOW_COLOR_RST = 24'h0000FF;
  localparam logic [COLOR_W-1:0] HIGH_COLOR_RST = 24'hFF0000;
  localparam logic [COLOR_W-1:0] MID_COLOR_RST = 24'h808080;

  typedef struct packed {
    logic fix;
    logic [COLOR_W-1:0] col;
    logic endh;
    logic zero;
  } tag_t;

  // Exact for every value up to 255 * 100.
  function automatic logic [CHAN_W-1:0] div100(input logic [SUM_W-1:0] x);
    logic [PROD_W-1:0] prod;
    prod = PROD_W'(x) * PROD_W'(DIV100_MUL);
    return prod[DIV100_SHIFT +: CHAN_W];
  endfunction

endpackage

// ===== hw/rtl/elevation_color_ramp.sv =====
// Colours one height-map point per beat.
// The point channel (point_valid/point_ready) carries a signed height and a
// preset colour; a nonzero preset passes through unchanged. The colour
// channel (color_valid/color_ready) returns one 24-bit 0xRRGGBB colour per
// point, in order. Other points take the low, high or mid colour at the
// extremes and at zero, or a blend of mid and an end colour by a percentage
// of the height against the extreme of its sign.
// The datapath is twelve register stages: input decode, an eight-step
// restoring divider for the percentage, percentage clamp, channel products
// and the output register. One beat is accepted every cycle unless the
// receiver stalls a full pipeline.
// Each stage moves when it is empty or the stage after it moves, so a stall
// of the receiver fills bubbles first and back-pressures the point channel
// only when every stage holds a beat. Nothing is lost or repeated.
// The user must write registers via cfg_we/cfg_index/cfg_data only while no
// point is in flight; the block does not enforce it. Unused indices are
// ignored. Synchronous reset empties the pipeline and restores reset values.
module elevation_color_ramp #(
  parameter int HEIGHT_WIDTH = ecr_pkg::HEIGHT_WIDTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [ecr_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [((HEIGHT_WIDTH > ecr_pkg::COLOR_W) ? HEIGHT_WIDTH : ecr_pkg::COLOR_W)-1:0]
                                               cfg_data,
  input  logic                                 point_valid,
  output logic                                 point_ready,
  input  logic signed [HEIGHT_WIDTH-1:0]       height,
  input  logic [ecr_pkg::COLOR_W-1:0]          preset_color,
  output logic                                 color_valid,
  input  logic                                 color_ready,
  output logic [ecr_pkg::COLOR_W-1:0]          point_color
);

  localparam int HW = HEIGHT_WIDTH;
  localparam int CW = ecr_pkg::COLOR_W;
  localparam int QW = ecr_pkg::Q_W;
  localparam int DW = HW + QW;
  localparam int NDS = QW + 1;
  localparam int S_DIV = 1;
  localparam int S_P = S_DIV + NDS;
  localparam int S_M = S_P + 1;
  localparam int S_O = S_M + 1;
  localparam int NST = S_O + 1;

  logic signed [HW-1:0] min_height;
  logic signed [HW-1:0] max_height;
  logic [CW-1:0]        low_color;
  logic [CW-1:0]        high_color;
  logic [CW-1:0]        mid_color;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_height <= '0;
      max_height <= '0;
      low_color  <= ecr_pkg::LOW_COLOR_RST;
      high_color <= ecr_pkg::HIGH_COLOR_RST;
      mid_color  <= ecr_pkg::MID_COLOR_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        ecr_pkg::REG_MIN_HEIGHT: min_height <= $signed(cfg_data[HW-1:0]);
        ecr_pkg::REG_MAX_HEIGHT: max_height <= $signed(cfg_data[HW-1:0]);
        ecr_pkg::REG_LOW_COLOR:  low_color  <= cfg_data[CW-1:0];
        ecr_pkg::REG_HIGH_COLOR: high_color <= cfg_data[CW-1:0];
        ecr_pkg::REG_MID_COLOR:  mid_color  <= cfg_data[CW-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline flow control.
  logic [NST-1:0] vld;
  logic [NST-1:0] adv;

  assign adv[NST-1] = !vld[NST-1] || color_ready;
  for (genvar i = 0; i < NST - 1; i++) begin : g_adv
    assign adv[i] = !vld[i] || adv[i+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) begin
        vld[0] <= point_valid;
      end
      for (int i = 1; i < NST; i++) begin
        if (adv[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  assign point_ready = adv[0];
  assign color_valid = vld[S_O];

  // Stage 0: classify the point and form the dividend and divisor magnitudes.
  logic [HW-1:0]  hu;
  logic [HW-1:0]  eu;
  logic           isneg;
  logic           ext_neg;
  logic [HW-1:0]  absz;
  logic [HW-1:0]  bmag;
  logic [DW-1:0]  absz_w;
  ecr_pkg::tag_t  tag_next;

  always_comb begin
    hu      = $unsigned(height);
    isneg   = height[HW-1];
    eu      = isneg ? $unsigned(min_height) : $unsigned(max_height);
    ext_neg = eu[HW-1];
    absz    = isneg ? (~hu + {{(HW-1){1'b0}}, 1'b1}) : hu;
    if (eu == '0) begin
      bmag = {{(HW-1){1'b0}}, 1'b1};
    end else if (ext_neg) begin
      bmag = ~eu + {{(HW-1){1'b0}}, 1'b1};
    end else begin
      bmag = eu;
    end
    absz_w = {{QW{1'b0}}, absz};

    tag_next.endh = !isneg;
    tag_next.zero = isneg ? !ext_neg : ext_neg;
    tag_next.fix  = 1'b1;
    if (preset_color != '0) begin
      tag_next.col = preset_color;
    end else if (height == min_height && min_height[HW-1]) begin
      tag_next.col = low_color;
    end else if (height == max_height && !max_height[HW-1] && max_height != '0) begin
      tag_next.col = high_color;
    end else if (height == '0) begin
      tag_next.col = mid_color;
    end else begin
      tag_next.col = '0;
      tag_next.fix = 1'b0;
    end
  end

  ecr_pkg::tag_t tag0;
  logic [DW-1:0] a0;
  logic [HW-1:0] b0;

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      tag0 <= tag_next;
      a0   <= (absz_w << 6) + (absz_w << 5) + (absz_w << 2);
      b0   <= bmag;
    end
  end

  // Restoring divider, one quotient bit per stage. The first stage only
  // checks whether the quotient reaches 128 and would overflow its 7 bits.
  ecr_pkg::tag_t dtag [NDS];
  logic          dsat [NDS];
  logic [DW-1:0] dr   [NDS];
  logic [HW-1:0] db   [NDS];
  logic [QW-1:0] dq   [NDS];

  always_ff @(posedge clk) begin
    if (adv[S_DIV]) begin
      dtag[0] <= tag0;
      dsat[0] <= a0 >= ({{QW{1'b0}}, b0} << QW);
      dr[0]   <= a0;
      db[0]   <= b0;
      dq[0]   <= '0;
    end
  end

  for (genvar k = 1; k < NDS; k++) begin : g_div
    localparam int BIT = QW - k;
    logic [DW-1:0] trial;
    logic          fits;

    assign trial = {{QW{1'b0}}, db[k-1]} << BIT;
    assign fits  = dr[k-1] >= trial;

    always_ff @(posedge clk) begin
      if (adv[S_DIV+k]) begin
        dtag[k] <= dtag[k-1];
        dsat[k] <= dsat[k-1];
        db[k]   <= db[k-1];
        dr[k]   <= fits ? (dr[k-1] - trial) : dr[k-1];
        dq[k]   <= dq[k-1] | (fits ? (QW'(1) << BIT) : '0);
      end
    end
  end

  // Percentage clamp.
  ecr_pkg::tag_t tagp;
  logic [QW-1:0] pp;

  always_ff @(posedge clk) begin
    if (adv[S_P]) begin
      tagp <= dtag[NDS-1];
      if (dtag[NDS-1].zero) begin
        pp <= '0;
      end else if (dsat[NDS-1] || dq[NDS-1] > QW'(ecr_pkg::PCT_FULL)) begin
        pp <= QW'(ecr_pkg::PCT_FULL);
      end else begin
        pp <= dq[NDS-1];
      end
    end
  end

  // Weighted channel sums.
  ecr_pkg::tag_t                       tagm;
  logic [ecr_pkg::SUM_W-1:0]           sm [ecr_pkg::NUM_CHAN];
  logic [CW-1:0]                       end_color;
  logic [QW-1:0]                       pinv;

  assign end_color = tagp.endh ? high_color : low_color;
  assign pinv      = QW'(ecr_pkg::PCT_FULL) - pp;

  always_ff @(posedge clk) begin
    if (adv[S_M]) begin
      tagm <= tagp;
      for (int c = 0; c < ecr_pkg::NUM_CHAN; c++) begin
        sm[c] <= ecr_pkg::SUM_W'(mid_color[c*ecr_pkg::CHAN_W +: ecr_pkg::CHAN_W])
                   * ecr_pkg::SUM_W'(pinv)
               + ecr_pkg::SUM_W'(end_color[c*ecr_pkg::CHAN_W +: ecr_pkg::CHAN_W])
                   * ecr_pkg::SUM_W'(pp);
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (adv[S_O]) begin
      if (tagm.fix) begin
        point_color <= tagm.col;
      end else begin
        point_color <= {ecr_pkg::div100(sm[2]), ecr_pkg::div100(sm[1]),
                        ecr_pkg::div100(sm[0])};
      end
    end
  end

`ifndef SYNTHESIS
  a_pct_range: assert property (@(posedge clk) disable iff (rst)
    vld[S_P] |-> pp <= QW'(ecr_pkg::PCT_FULL))
    else $error("blend percentage above full scale");

  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    (vld[S_P-1] && !dsat[NDS-1]) |-> dr[NDS-1] < {{QW{1'b0}}, db[NDS-1]})
    else $error("divider remainder not below divisor");

  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    (vld == {NST{1'b1}} && !color_ready) |-> !point_ready)
    else $error("point accepted into a full stalled pipeline");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    (vld[S_M] && adv[S_O]) |=> color_valid)
    else $error("beat lost between last two stages");
`endif

endmodule
